// File: hdl/gbn_pkg.sv
// Shared types and constants for the greedy box suppression unit.
// Used by the controller, the datapath and the top level; no dependencies.
package gbn_pkg;

  localparam int MAX_BOXES_DEF = 64;
  localparam int COORD_W       = 16;
  localparam int SCORE_W       = 16;
  localparam int THRESH_W      = 16;
  localparam int KEPT_CFG_W    = 7;
  localparam int KEPT_IDX_W    = 6;
  localparam int AREA_W        = 34;
  localparam int IN_DATA_W     = 80;
  localparam int OUT_DATA_W    = 8;
  localparam int CFG_DATA_W    = 16;
  localparam int CFG_INDEX_W   = 1;
  localparam int RESULT_LIMIT  = 64;
  localparam logic [15:0] THRESH_RESET = 16'd36045;
  localparam logic [6:0]  KEPT_RESET   = 7'd64;
  localparam logic [CFG_INDEX_W-1:0] REG_IOU_THRESHOLD = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_KEPT      = 1'b1;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_RK_HEAD,
    ST_RK_HOLD,
    ST_RK_SCAN,
    ST_RK_DRAIN,
    ST_RK_WRITE,
    ST_SP_START,
    ST_SP_FETCH,
    ST_SP_WAIT,
    ST_SP_DECIDE,
    ST_SP_KEEP,
    ST_SP_SCAN,
    ST_SP_DRAIN,
    ST_SP_FINISH
  } gbn_state_t;

  typedef struct packed {
    logic load_we;
    logic rank_clear;
    logic score_latch;
    logic score_issue;
    logic rank_we;
    logic supp_clear;
    logic pair_issue;
    logic best_latch;
    logic push;
    logic push_last;
    logic set_pending;
    logic pend_clear;
  } gbn_cmd_t;

  typedef struct packed {
    logic       busy;
    logic       best_supp;
    logic       out_free;
    logic       pend_valid;
    logic [6:0] limit;
  } gbn_status_t;

endpackage

// File: hdl/gbn_ctrl.sv
// Controller state machine: sequences loading, ranking by score and the
// greedy suppression passes. Depends on gbn_pkg; drives gbn_dp by commands.
module gbn_ctrl import gbn_pkg::*; #(
  parameter int MAX_BOXES = MAX_BOXES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_last,
  output logic                           in_ready,
  input  gbn_status_t                    status,
  output gbn_cmd_t                       cmd,
  output logic [$clog2(MAX_BOXES)-1:0]   load_addr,
  output logic [$clog2(MAX_BOXES)-1:0]   score_addr,
  output logic [$clog2(MAX_BOXES)-1:0]   rank_addr,
  output logic [$clog2(MAX_BOXES)-1:0]   cur_idx
);

  localparam int IW = $clog2(MAX_BOXES);
  localparam int CW = $clog2(MAX_BOXES + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_BOXES);
  localparam logic [CW-1:0] ONE     = CW'(1);

  gbn_state_t state, state_next;
  logic [CW-1:0] n, n_next;
  logic [CW-1:0] i, i_next;
  logic [CW-1:0] j, j_next;
  logic [CW-1:0] r, r_next;
  logic [CW-1:0] s, s_next;
  logic [6:0]    kept, kept_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      n     <= '0;
      i     <= '0;
      j     <= '0;
      r     <= '0;
      s     <= '0;
      kept  <= '0;
    end else begin
      state <= state_next;
      n     <= n_next;
      i     <= i_next;
      j     <= j_next;
      r     <= r_next;
      s     <= s_next;
      kept  <= kept_next;
    end
  end

  always_comb begin
    state_next = state;
    n_next     = n;
    i_next     = i;
    j_next     = j;
    r_next     = r;
    s_next     = s;
    kept_next  = kept;
    cmd        = '0;
    in_ready   = 1'b0;
    load_addr  = n[IW-1:0];
    score_addr = i[IW-1:0];
    rank_addr  = r[IW-1:0];
    cur_idx    = i[IW-1:0];
    case (state)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (n < MAX_CNT) begin
            cmd.load_we = 1'b1;
            n_next      = n + ONE;
          end
          if (in_last) begin
            i_next = '0;
            if (n_next != '0) begin
              state_next = ST_RK_HEAD;
            end
          end
        end
      end
      ST_RK_HEAD: begin
        cmd.rank_clear = 1'b1;
        state_next     = ST_RK_HOLD;
      end
      ST_RK_HOLD: begin
        cmd.score_latch = 1'b1;
        j_next          = '0;
        state_next      = ST_RK_SCAN;
      end
      ST_RK_SCAN: begin
        score_addr      = j[IW-1:0];
        cmd.score_issue = 1'b1;
        j_next          = j + ONE;
        if (j == n - ONE) begin
          state_next = ST_RK_DRAIN;
        end
      end
      ST_RK_DRAIN: begin
        if (!status.busy) begin
          state_next = ST_RK_WRITE;
        end
      end
      ST_RK_WRITE: begin
        cmd.rank_we = 1'b1;
        i_next      = i + ONE;
        state_next  = (i == n - ONE) ? ST_SP_START : ST_RK_HEAD;
      end
      ST_SP_START: begin
        cmd.supp_clear = 1'b1;
        cmd.pend_clear = 1'b1;
        r_next         = '0;
        kept_next      = '0;
        state_next     = ST_SP_FETCH;
      end
      ST_SP_FETCH: begin
        state_next = ST_SP_WAIT;
      end
      ST_SP_WAIT: begin
        state_next = ST_SP_DECIDE;
      end
      ST_SP_DECIDE: begin
        if (status.best_supp) begin
          r_next     = r + ONE;
          state_next = (r == n - ONE) ? ST_SP_FINISH : ST_SP_FETCH;
        end else begin
          cmd.best_latch = 1'b1;
          state_next     = ST_SP_KEEP;
        end
      end
      ST_SP_KEEP: begin
        if (!status.pend_valid || status.out_free) begin
          cmd.push        = status.pend_valid;
          cmd.set_pending = 1'b1;
          kept_next       = kept + 7'd1;
          s_next          = r + ONE;
          if (kept + 7'd1 == status.limit || r == n - ONE) begin
            state_next = ST_SP_FINISH;
          end else begin
            state_next = ST_SP_SCAN;
          end
        end
      end
      ST_SP_SCAN: begin
        rank_addr      = s[IW-1:0];
        cmd.pair_issue = 1'b1;
        s_next         = s + ONE;
        if (s == n - ONE) begin
          state_next = ST_SP_DRAIN;
        end
      end
      ST_SP_DRAIN: begin
        if (!status.busy) begin
          r_next     = r + ONE;
          state_next = (r == n - ONE) ? ST_SP_FINISH : ST_SP_FETCH;
        end
      end
      ST_SP_FINISH: begin
        if (!status.pend_valid) begin
          n_next     = '0;
          state_next = ST_LOAD;
        end else if (status.out_free) begin
          cmd.push       = 1'b1;
          cmd.push_last  = 1'b1;
          cmd.pend_clear = 1'b1;
          n_next         = '0;
          state_next     = ST_LOAD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

endmodule

// File: hdl/gbn_dp.sv
// Datapath: box, score, area and rank memories, the score compare pipe,
// the overlap pipe, the suppression flags and the output register. Uses gbn_pkg.
module gbn_dp import gbn_pkg::*; #(
  parameter int MAX_BOXES = MAX_BOXES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [IN_DATA_W-1:0]              in_data,
  input  logic                              cfg_we,
  input  logic [CFG_INDEX_W-1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0]             cfg_data,
  input  gbn_cmd_t                          cmd,
  input  logic [$clog2(MAX_BOXES)-1:0]      load_addr,
  input  logic [$clog2(MAX_BOXES)-1:0]      score_addr,
  input  logic [$clog2(MAX_BOXES)-1:0]      rank_addr,
  input  logic [$clog2(MAX_BOXES)-1:0]      cur_idx,
  output gbn_status_t                       status,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [KEPT_IDX_W-1:0]             out_index,
  output logic                              out_last
);

  localparam int IW = $clog2(MAX_BOXES);

  logic [THRESH_W-1:0]   threshold;
  logic [KEPT_CFG_W-1:0] max_kept;
  logic [KEPT_CFG_W-1:0] limit;

  logic [4*COORD_W-1:0]  corner_mem [MAX_BOXES];
  logic [SCORE_W-1:0]    score_mem  [MAX_BOXES];
  logic [AREA_W-1:0]     area_mem   [MAX_BOXES];
  logic [IW-1:0]         rank_mem   [MAX_BOXES];

  logic signed [17:0] ld_dx, ld_dy;
  logic signed [35:0] ld_area;

  logic [SCORE_W-1:0] score_rd, score_i;
  logic               sv1;
  logic [IW-1:0]      stag1;
  logic [IW-1:0]      rank_cnt;

  logic [IW-1:0]        rank_rd;
  logic [4*COORD_W-1:0] corner_rd;
  logic [AREA_W-1:0]    area_rd;
  logic [IW-1:0]        tag2;
  logic                 v1, v2, v3, v4, v5, v6;
  logic [IW-1:0]        tag3, tag4, tag5, tag6;

  logic signed [COORD_W-1:0] bx1, by1, bx2, by2;
  logic signed [AREA_W-1:0]  barea;
  logic [IW-1:0]             best_idx;

  logic signed [COORD_W-1:0] ox1, oy1, ox2, oy2;
  logic signed [COORD_W-1:0] ix1, iy1, ix2, iy2;
  logic signed [17:0]        iw, ih;
  logic [16:0]               w3, h3;
  logic signed [AREA_W-1:0]  area3, area4;
  logic [33:0]               inter4, inter5;
  logic signed [35:0]        uni5;
  logic [49:0]               lhs6;
  logic signed [52:0]        prod6;

  logic [MAX_BOXES-1:0] supp;
  logic [IW-1:0]        pend_idx;
  logic                 pend_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESH_RESET;
      max_kept  <= KEPT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IOU_THRESHOLD: threshold <= cfg_data[THRESH_W-1:0];
        REG_MAX_KEPT:      max_kept  <= cfg_data[KEPT_CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (max_kept == '0) begin
      limit = 7'd1;
    end else if (max_kept > 7'(RESULT_LIMIT)) begin
      limit = 7'(RESULT_LIMIT);
    end else begin
      limit = max_kept;
    end
  end

  assign status.limit = limit;

  assign ld_dx   = 18'(signed'(in_data[47:32])) - 18'(signed'(in_data[15:0])) + 18'sd16;
  assign ld_dy   = 18'(signed'(in_data[63:48])) - 18'(signed'(in_data[31:16])) + 18'sd16;
  assign ld_area = ld_dx * ld_dy;

  always_ff @(posedge clk) begin
    if (cmd.load_we) begin
      corner_mem[load_addr] <= in_data[63:0];
      score_mem[load_addr]  <= in_data[79:64];
      area_mem[load_addr]   <= ld_area[AREA_W-1:0];
    end
    score_rd <= score_mem[score_addr];
    if (cmd.rank_we) begin
      rank_mem[rank_cnt] <= cur_idx;
    end
    rank_rd   <= rank_mem[rank_addr];
    corner_rd <= corner_mem[rank_rd];
    area_rd   <= area_mem[rank_rd];
    tag2      <= rank_rd;
  end

  // Rank of a box: the number of boxes that score higher, or equal with a
  // lower load index.
  always_ff @(posedge clk) begin
    if (rst) begin
      sv1 <= 1'b0;
    end else begin
      sv1 <= cmd.score_issue;
    end
    stag1 <= score_addr;
    if (cmd.score_latch) begin
      score_i <= score_rd;
    end
    if (cmd.rank_clear) begin
      rank_cnt <= '0;
    end else if (sv1 && (score_rd > score_i || (score_rd == score_i && stag1 < cur_idx))) begin
      rank_cnt <= rank_cnt + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.best_latch) begin
      bx1      <= corner_rd[15:0];
      by1      <= corner_rd[31:16];
      bx2      <= corner_rd[47:32];
      by2      <= corner_rd[63:48];
      barea    <= area_rd;
      best_idx <= tag2;
    end
  end

  assign ox1 = corner_rd[15:0];
  assign oy1 = corner_rd[31:16];
  assign ox2 = corner_rd[47:32];
  assign oy2 = corner_rd[63:48];
  assign ix1 = (bx1 > ox1) ? bx1 : ox1;
  assign iy1 = (by1 > oy1) ? by1 : oy1;
  assign ix2 = (bx2 < ox2) ? bx2 : ox2;
  assign iy2 = (by2 < oy2) ? by2 : oy2;
  assign iw  = 18'(ix2) - 18'(ix1) + 18'sd16;
  assign ih  = 18'(iy2) - 18'(iy1) + 18'sd16;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      v1 <= cmd.pair_issue;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
    w3     <= iw[17] ? 17'd0 : iw[16:0];
    h3     <= ih[17] ? 17'd0 : ih[16:0];
    area3  <= area_rd;
    tag3   <= tag2;
    inter4 <= w3 * h3;
    area4  <= area3;
    tag4   <= tag3;
    uni5   <= 36'(barea) + 36'(area4) - 36'(signed'({1'b0, inter4}));
    inter5 <= inter4;
    tag5   <= tag4;
    prod6  <= signed'({1'b0, threshold}) * uni5;
    lhs6   <= {inter5, 16'd0};
    tag6   <= tag5;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.supp_clear) begin
      supp <= '0;
    end else if (v6 && signed'({3'b000, lhs6}) > prod6) begin
      supp[tag6] <= 1'b1;
    end
  end

  assign status.busy      = sv1 | v1 | v2 | v3 | v4 | v5 | v6;
  assign status.best_supp = supp[tag2];
  assign status.out_free  = !out_valid || out_ready;
  assign status.pend_valid = pend_valid;

  always_ff @(posedge clk) begin
    if (rst || cmd.pend_clear) begin
      pend_valid <= 1'b0;
    end else if (cmd.set_pending) begin
      pend_valid <= 1'b1;
    end
    if (cmd.set_pending) begin
      pend_idx <= best_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.push) begin
      out_index <= KEPT_IDX_W'(pend_idx);
      out_last  <= cmd.push_last;
    end
  end

endmodule

// File: hdl/greedy_box_nms_unit.sv
// Top level of the greedy box suppression unit.
// Joins gbn_ctrl and gbn_dp; uses gbn_pkg.
//
// Boxes enter on the s_axis channel, one beat per cycle while the unit
// is loading. tuser marks the last box of a set; up to MAX_BOXES boxes
// are held and further boxes of a set are dropped. After the last beat
// the input is held off while the set is ranked by score, one score
// memory read per cycle, and then suppressed: each kept box is compared
// with every lower ranked box, one per cycle, through the overlap pipe.
// Kept load indices leave on m_axis in rank order, tlast on the final
// one; at most max_kept of them are sent, a max_kept of 0 counting as 1
// and one above 64 as 64. The output beat is registered behind a pending
// index, so a stalled receiver only pauses the suppression pass when a
// new kept index is ready while both are full. Reset clears the held set
// and sets the registers to a threshold of 0.55 and a limit of 64. Registers are
// to be written only between sets.
module greedy_box_nms_unit import gbn_pkg::*; #(
  parameter int MAX_BOXES = MAX_BOXES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // left_edge, top_edge, right_edge, bottom_edge, box_score
  input  logic [IN_DATA_W-1:0]   s_axis_tdata,
  // last_box
  input  logic                   s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // kept_index, two zero bits
  output logic [OUT_DATA_W-1:0]  m_axis_tdata,
  output logic                   m_axis_tlast,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int IW = $clog2(MAX_BOXES);

  gbn_cmd_t    cmd;
  gbn_status_t status;
  logic [IW-1:0] load_addr, score_addr, rank_addr, cur_idx;
  logic [KEPT_IDX_W-1:0] out_index;

  gbn_ctrl #(.MAX_BOXES(MAX_BOXES)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_last    (s_axis_tuser),
    .in_ready   (s_axis_tready),
    .status     (status),
    .cmd        (cmd),
    .load_addr  (load_addr),
    .score_addr (score_addr),
    .rank_addr  (rank_addr),
    .cur_idx    (cur_idx)
  );

  gbn_dp #(.MAX_BOXES(MAX_BOXES)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .in_data    (s_axis_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .load_addr  (load_addr),
    .score_addr (score_addr),
    .rank_addr  (rank_addr),
    .cur_idx    (cur_idx),
    .status     (status),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_index  (out_index),
    .out_last   (m_axis_tlast)
  );

  assign m_axis_tdata = {{(OUT_DATA_W-KEPT_IDX_W){1'b0}}, out_index};

endmodule

// File: sim/gbn_survivor_checker.sv
`timescale 1ns / 100ps
// Watches the box, result and register channels of greedy_box_nms_unit, predicts the
// surviving box indices of each set and compares every result beat. Uses gbn_pkg.
module gbn_survivor_checker import gbn_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [IN_DATA_W-1:0]   s_axis_tdata,
  input  logic                   s_axis_tuser,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [OUT_DATA_W-1:0]  m_axis_tdata,
  input  logic                   m_axis_tlast,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     fail_count,
  output int                     kept_pending,
  output int                     kept_seen,
  output int                     sets_seen
);

  typedef struct {
    logic [KEPT_IDX_W-1:0] index;
    logic                  last;
  } kept_t;

  kept_t kept_q[$];

  logic signed [COORD_W-1:0] box_l[RESULT_LIMIT], box_t[RESULT_LIMIT];
  logic signed [COORD_W-1:0] box_r[RESULT_LIMIT], box_b[RESULT_LIMIT];
  logic [SCORE_W-1:0]        box_score[RESULT_LIMIT];
  longint                    box_area[RESULT_LIMIT];
  int                        held;
  logic [THRESH_W-1:0]       iou_limit;
  logic [KEPT_CFG_W-1:0]     kept_limit;

  function automatic bit too_close(int a, int b);
    longint w, h, inter, uni;
    w = longint'(box_r[a] < box_r[b] ? box_r[a] : box_r[b]) -
        longint'(box_l[a] > box_l[b] ? box_l[a] : box_l[b]) + 16;
    h = longint'(box_b[a] < box_b[b] ? box_b[a] : box_b[b]) -
        longint'(box_t[a] > box_t[b] ? box_t[a] : box_t[b]) + 16;
    if (w < 0) w = 0;
    if (h < 0) h = 0;
    inter = w * h;
    uni = box_area[a] + box_area[b] - inter;
    return inter * 65536 > longint'(iou_limit) * uni;
  endfunction

  task automatic predict_survivors();
    int order[RESULT_LIMIT];
    bit gone[RESULT_LIMIT];
    int limit, count, j, cur;
    kept_t k;
    limit = kept_limit;
    if (limit == 0) limit = 1;
    if (limit > RESULT_LIMIT) limit = RESULT_LIMIT;
    for (int i = 0; i < held; i++) begin
      j = i;
      while (j > 0 && box_score[order[j-1]] < box_score[i]) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = i;
      gone[i] = 0;
    end
    count = 0;
    for (int r = 0; r < held && count < limit; r++) begin
      cur = order[r];
      if (!gone[cur]) begin
        k.index = cur[KEPT_IDX_W-1:0];
        k.last = 0;
        kept_q.insert(kept_q.size(), k);
        count++;
        for (int s = r + 1; s < held; s++)
          if (!gone[order[s]] && too_close(cur, order[s])) gone[order[s]] = 1;
      end
    end
    if (count > 0) kept_q[kept_q.size()-1].last = 1;
    held = 0;
  endtask

  always @(posedge clk) begin
    kept_t want;
    if (rst) begin
      kept_q.delete();
      held = 0;
      iou_limit = THRESH_RESET;
      kept_limit = KEPT_RESET;
      fail_count = 0;
      kept_seen = 0;
      sets_seen = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_IOU_THRESHOLD) iou_limit = cfg_data[THRESH_W-1:0];
        else if (cfg_index == REG_MAX_KEPT) kept_limit = cfg_data[KEPT_CFG_W-1:0];
      end
      if (m_axis_tvalid && m_axis_tready) begin
        kept_seen++;
        if (kept_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result beat: index %0d last %0b",
                     m_axis_tdata[KEPT_IDX_W-1:0], m_axis_tlast);
        end else begin
          want = kept_q.pop_front();
          if (m_axis_tdata !== {{(OUT_DATA_W-KEPT_IDX_W){1'b0}}, want.index} ||
              m_axis_tlast !== want.last) begin
            fail_count++;
            if (fail_count <= 10)
              $display("result mismatch: expected index %0d last %0b, got data %h last %0b",
                       want.index, want.last, m_axis_tdata, m_axis_tlast);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (held < RESULT_LIMIT) begin
          box_l[held] = s_axis_tdata[15:0];
          box_t[held] = s_axis_tdata[31:16];
          box_r[held] = s_axis_tdata[47:32];
          box_b[held] = s_axis_tdata[63:48];
          box_score[held] = s_axis_tdata[79:64];
          box_area[held] = (longint'(box_r[held]) - box_l[held] + 16) *
                           (longint'(box_b[held]) - box_t[held] + 16);
          held++;
        end
        if (s_axis_tuser) begin
          sets_seen++;
          predict_survivors();
        end
      end
    end
    kept_pending = kept_q.size();
  end

endmodule

// File: sim/tb_greedy_box_nms_unit.sv
`timescale 1ns / 100ps
// Stimulus and verdict for greedy_box_nms_unit: drives box sets, register writes and
// receiver stalls. Depends on gbn_pkg, the unit and gbn_survivor_checker.
module tb_greedy_box_nms_unit;
  import gbn_pkg::*;

  logic clk = 0, rst = 1;
  logic s_axis_tvalid = 0, s_axis_tuser = 0, m_axis_tready = 0;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic s_axis_tready, m_axis_tvalid, m_axis_tlast;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic cfg_we = 0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int fail_count, kept_pending, kept_seen, sets_seen;
  int boxes_sent = 0, cycles = 0;
  bit long_hold = 0;

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  greedy_box_nms_unit dut (.*);
  gbn_survivor_checker checker_i (.*);

  always @(posedge clk) begin
    cycles++;
    if (cycles > 1000000) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int hold_len;
    m_axis_tready <= 0;
    forever begin
      if (long_hold) begin
        m_axis_tready <= 0;
        hold_len = 0;
        while (hold_len < 3000) begin
          @(posedge clk);
          hold_len++;
        end
        long_hold = 0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 3) != 0);
        @(posedge clk);
        if ($urandom_range(0, 40) == 0) begin
          m_axis_tready <= 0;
          repeat ($urandom_range(20, 120)) @(posedge clk);
        end else if ($urandom_range(0, 5) == 0) begin
          m_axis_tready <= 1;
          repeat ($urandom_range(10, 60)) @(posedge clk);
        end
      end
    end
  end

  task automatic send_box(logic [15:0] l, t, r, b, sc, logic last, bit burst);
    int gap;
    gap = burst ? 0 : ($urandom_range(0, 9) == 0 ? $urandom_range(10, 50)
                                                  : $urandom_range(0, 2));
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {sc, b, r, t, l};
    s_axis_tuser <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    boxes_sent++;
  endtask

  task automatic send_random_box(logic last, int cx, int cy, bit burst);
    logic [15:0] l, t, r, b, sc;
    int w, h;
    sc = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 3) * 21845) : 16'($urandom);
    case ($urandom_range(0, 9))
      0: begin
        l = 16'($urandom); t = 16'($urandom); r = 16'($urandom); b = 16'($urandom);
      end
      1: begin
        l = 16'(cx) + 16'($urandom_range(0, 200));
        t = 16'(cy) + 16'($urandom_range(0, 200));
        r = l - 16'($urandom_range(0, 300));
        b = t + 16'($urandom_range(0, 300)) - 16'd150;
      end
      default: begin
        w = $urandom_range(0, 1200);
        h = $urandom_range(0, 1200);
        l = 16'(cx) + 16'($urandom_range(0, 160));
        t = 16'(cy) + 16'($urandom_range(0, 160));
        r = l + 16'(w);
        b = t + 16'(h);
      end
    endcase
    send_box(l, t, r, b, sc, last, burst);
  endtask

  task automatic send_set(int n, bit burst);
    int cx, cy;
    cx = $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 4000) - 2000;
    cy = $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 4000) - 2000;
    for (int i = 0; i < n; i++) send_random_box(i == n - 1, cx, cy, burst);
  endtask

  task automatic settle();
    s_axis_tvalid <= 0;
    s_axis_tuser <= 0;
    @(posedge clk);
    while (kept_pending != 0) @(posedge clk);
    repeat (5000) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  initial begin
    int n;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed sets: extreme corners, a lone box, equal scores, inverted and flat boxes.
    send_box(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'hFFFF, 0, 0);
    send_box(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h0000, 0, 0);
    send_box(16'h0000, 16'h0000, 16'h0100, 16'h0100, 16'hFFFF, 1, 0);
    send_box(16'hFFF0, 16'hFFF0, 16'hFFEF, 16'hFFEF, 16'h1234, 1, 0);
    for (int i = 0; i < 4; i++)
      send_box(16'h0010, 16'h0010, 16'h0200, 16'h0200, 16'h8000, i == 3, 0);
    send_box(16'h0000, 16'h0000, 16'h00F0, 16'h00F0, 16'h9000, 0, 0);
    send_box(16'h0050, 16'h0000, 16'h0140, 16'h00F0, 16'h8000, 0, 0);
    send_box(16'h0200, 16'h0200, 16'h0100, 16'h0100, 16'h7000, 0, 0);
    send_box(16'h0000, 16'h0000, 16'hFFE0, 16'h00F0, 16'h6000, 1, 0);
    settle();
    write_reg(REG_IOU_THRESHOLD, 16'd0);
    write_reg(REG_MAX_KEPT, 16'd0);
    for (int i = 0; i < 3; i++)
      send_box(16'h0000, 16'h0000, 16'h0100, 16'h0100, 16'(i * 100), i == 2, 0);
    settle();
    write_reg(REG_IOU_THRESHOLD, 16'hFFFF);
    write_reg(REG_MAX_KEPT, 16'd127);
    for (int i = 0; i < 4; i++)
      send_box(16'h0000, 16'h0000, 16'h0100, 16'h0100, 16'hFFFF, i == 3, 0);
    settle();
    write_reg(REG_IOU_THRESHOLD, THRESH_RESET);
    write_reg(REG_MAX_KEPT, 16'd64);

    // A long receiver hold while the next set waits behind a full output.
    send_set(12, 1);
    long_hold = 1;
    send_set(6, 1);

    while (boxes_sent < 390) begin
      case ($urandom_range(0, 24))
        0: n = $urandom_range(60, 70);
        1, 2: n = $urandom_range(15, 40);
        default: n = $urandom_range(1, 10);
      endcase
      send_set(n, $urandom_range(0, 4) == 0);
      if ($urandom_range(0, 7) == 0) begin
        settle();
        case ($urandom_range(0, 3))
          0: write_reg(REG_IOU_THRESHOLD, 16'($urandom));
          1: write_reg(REG_IOU_THRESHOLD, 16'($urandom_range(0, 1) ? 0 : 65535));
          2: write_reg(REG_MAX_KEPT, 16'($urandom_range(1, 4)));
          default: write_reg(REG_MAX_KEPT, 16'($urandom_range(0, 127)));
        endcase
      end
    end
    s_axis_tvalid <= 0;
    s_axis_tuser <= 0;
    @(posedge clk);
    while (kept_pending != 0) @(posedge clk);
    repeat (5000) @(posedge clk);

    $display("Sent %0d boxes in %0d sets and checked %0d kept indices,", boxes_sent,
             sets_seen, kept_seen);
    $display("over several threshold and limit settings and one long receiver hold.");
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("status: fail");
    end
    $finish;
  end

endmodule
